>>> rtl/fraction_reduce_gcd_defines.svh
// ----------------------------------------------------------------------------
// Fraction reduction assertion macros
// Shared property forms for the checker of the fraction reduction block.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_GCD_DEFINES_SVH
`define FRACTION_REDUCE_GCD_DEFINES_SVH

// Same-cycle implication, clocked by aclk and held off while aresetn is low.
`define FRGCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fraction_reduce_gcd: same-cycle property failed");

// Next-cycle implication, clocked by aclk and held off while aresetn is low.
`define FRGCD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fraction_reduce_gcd: next-cycle property failed");

`endif

>>> rtl/frgcd_pkg.sv
// ----------------------------------------------------------------------------
// Fraction reduction package
// Widths, microcode encoding, program table and divider interface types.
// ----------------------------------------------------------------------------
package frgcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int TDATA_W    = 2 * DATA_WIDTH;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int PC_W       = 4;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [PC_W-1:0]       pc_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_LOAD     = 4'd1,
        OP_DIV_REM  = 4'd2,
        OP_WB_REM   = 4'd3,
        OP_DIV_NUM  = 4'd4,
        OP_WB_QN    = 4'd5,
        OP_DIV_DEN  = 4'd6,
        OP_WB_QD    = 4'd7,
        OP_ERR_ZERO = 4'd8,
        OP_EMIT     = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        CND_NEXT     = 3'd0,
        CND_ALWAYS   = 3'd1,
        CND_NO_INPUT = 3'd2,
        CND_N_ZERO   = 3'd3,
        CND_DIV_BUSY = 3'd4,
        CND_OUT_BUSY = 3'd5
    } cond_t;

    localparam pc_t PC_IDLE     = 4'd0;
    localparam pc_t PC_CHKZ     = 4'd1;
    localparam pc_t PC_LOOP     = 4'd2;
    localparam pc_t PC_REM_GO   = 4'd3;
    localparam pc_t PC_REM_WAIT = 4'd4;
    localparam pc_t PC_REM_WB   = 4'd5;
    localparam pc_t PC_QN_GO    = 4'd6;
    localparam pc_t PC_QN_WAIT  = 4'd7;
    localparam pc_t PC_QN_WB    = 4'd8;
    localparam pc_t PC_QD_GO    = 4'd9;
    localparam pc_t PC_QD_WAIT  = 4'd10;
    localparam pc_t PC_QD_WB    = 4'd11;
    localparam pc_t PC_ZERO     = 4'd12;
    localparam pc_t PC_EMIT     = 4'd13;
    localparam pc_t PC_WRAP     = 4'd14;

    typedef struct packed {
        logic  accept;
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

    // A true condition loads the target; otherwise the step counter advances.
    function automatic ctrl_word_t microcode(input pc_t pc);
        ctrl_word_t cw;
        case (pc)
            PC_IDLE:     cw = '{1'b1, OP_LOAD,     CND_NO_INPUT, PC_IDLE};
            PC_CHKZ:     cw = '{1'b0, OP_NOP,      CND_N_ZERO,   PC_ZERO};
            PC_LOOP:     cw = '{1'b0, OP_NOP,      CND_N_ZERO,   PC_QN_GO};
            PC_REM_GO:   cw = '{1'b0, OP_DIV_REM,  CND_NEXT,     PC_IDLE};
            PC_REM_WAIT: cw = '{1'b0, OP_NOP,      CND_DIV_BUSY, PC_REM_WAIT};
            PC_REM_WB:   cw = '{1'b0, OP_WB_REM,   CND_ALWAYS,   PC_LOOP};
            PC_QN_GO:    cw = '{1'b0, OP_DIV_NUM,  CND_NEXT,     PC_IDLE};
            PC_QN_WAIT:  cw = '{1'b0, OP_NOP,      CND_DIV_BUSY, PC_QN_WAIT};
            PC_QN_WB:    cw = '{1'b0, OP_WB_QN,    CND_NEXT,     PC_IDLE};
            PC_QD_GO:    cw = '{1'b0, OP_DIV_DEN,  CND_NEXT,     PC_IDLE};
            PC_QD_WAIT:  cw = '{1'b0, OP_NOP,      CND_DIV_BUSY, PC_QD_WAIT};
            PC_QD_WB:    cw = '{1'b0, OP_WB_QD,    CND_ALWAYS,   PC_EMIT};
            PC_ZERO:     cw = '{1'b0, OP_ERR_ZERO, CND_NEXT,     PC_IDLE};
            PC_EMIT:     cw = '{1'b0, OP_EMIT,     CND_OUT_BUSY, PC_EMIT};
            PC_WRAP:     cw = '{1'b0, OP_NOP,      CND_ALWAYS,   PC_IDLE};
            default:     cw = '{1'b0, OP_NOP,      CND_ALWAYS,   PC_IDLE};
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/fraction_reduce_gcd.sv
// ----------------------------------------------------------------------------
// Fraction reduction by greatest common divisor
// Reduces a signed numerator and denominator by their Euclidean divisor.
//
// Each word on the slave side is one fraction; one result word follows it on
// the master side. A short microprogram drives one shared restoring divider
// that produces one quotient bit per cycle. Each remainder step of the
// Euclidean loop runs one division, and two final divisions then give the
// reduced numerator and denominator; the number of remainder steps is
// at most about 46 for 32-bit operands. A zero denominator skips the divider
// and goes straight from the zero check to the output step. The divisor
// keeps the sign that the truncating remainder gives it. Status 1 marks a zero
// denominator and status 2 a quotient that overflows; both return zero data.
// The result register lets the next word be accepted while a result waits.
// ----------------------------------------------------------------------------
module fraction_reduce_gcd (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [frgcd_pkg::TDATA_W-1:0]  s_tdata,  // numerator, denominator
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [frgcd_pkg::TDATA_W-1:0]  m_tdata,  // reduced_numerator, reduced_denominator
    output logic [1:0]                     m_tuser   // status
);

    localparam int DW = frgcd_pkg::DATA_WIDTH;

    frgcd_pkg::pc_t        pc_reg, pc_next;
    frgcd_pkg::ctrl_word_t cw;
    frgcd_pkg::div_req_t   div_req;
    frgcd_pkg::div_rsp_t   div_rsp;

    logic             num_neg_reg, num_neg_next;
    frgcd_pkg::word_t num_mag_reg, num_mag_next;
    logic             den_neg_reg, den_neg_next;
    frgcd_pkg::word_t den_mag_reg, den_mag_next;
    logic             m_neg_reg, m_neg_next;
    frgcd_pkg::word_t m_mag_reg, m_mag_next;
    logic             n_neg_reg, n_neg_next;
    frgcd_pkg::word_t n_mag_reg, n_mag_next;
    frgcd_pkg::word_t qn_reg, qn_next;
    frgcd_pkg::word_t qd_reg, qd_next;
    logic             zero_err_reg, zero_err_next;
    logic             ovf_reg, ovf_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [frgcd_pkg::TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                    m_tuser_reg, m_tuser_next;

    frgcd_pkg::word_t in_num, in_den, q;
    logic             in_accept, out_busy, cond_hit, n_zero;
    logic             q_neg_qn, q_neg_qd;

    assign cw        = frgcd_pkg::microcode(pc_reg);
    assign s_tready  = cw.accept;
    assign in_accept = s_tvalid & cw.accept;
    assign out_busy  = m_tvalid_reg & ~m_tready;
    assign n_zero    = (n_mag_reg == '0);
    assign in_num    = s_tdata[DW-1:0];
    assign in_den    = s_tdata[2*DW-1:DW];
    assign q         = div_rsp.quotient;
    assign q_neg_qn  = (num_neg_reg ^ m_neg_reg) & (q != '0);
    assign q_neg_qd  = (den_neg_reg ^ m_neg_reg) & (q != '0);

    always_comb begin
        case (cw.cond)
            frgcd_pkg::CND_NEXT:     cond_hit = 1'b0;
            frgcd_pkg::CND_ALWAYS:   cond_hit = 1'b1;
            frgcd_pkg::CND_NO_INPUT: cond_hit = ~s_tvalid;
            frgcd_pkg::CND_N_ZERO:   cond_hit = n_zero;
            frgcd_pkg::CND_DIV_BUSY: cond_hit = div_rsp.busy;
            frgcd_pkg::CND_OUT_BUSY: cond_hit = out_busy;
            default:                 cond_hit = 1'b1;
        endcase
        pc_next = cond_hit ? cw.target : pc_reg + 1'b1;
    end

    always_comb begin
        num_neg_next     = num_neg_reg;
        num_mag_next     = num_mag_reg;
        den_neg_next     = den_neg_reg;
        den_mag_next     = den_mag_reg;
        m_neg_next       = m_neg_reg;
        m_mag_next       = m_mag_reg;
        n_neg_next       = n_neg_reg;
        n_mag_next       = n_mag_reg;
        qn_next          = qn_reg;
        qd_next          = qd_reg;
        zero_err_next    = zero_err_reg;
        ovf_next         = ovf_reg;
        div_req.start    = 1'b0;
        div_req.dividend = m_mag_reg;
        div_req.divisor  = n_mag_reg;
        m_tvalid_next    = m_tvalid_reg & ~m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        case (cw.op)
            frgcd_pkg::OP_LOAD: begin
                if (in_accept) begin
                    num_neg_next  = in_num[DW-1];
                    num_mag_next  = in_num[DW-1] ? -in_num : in_num;
                    den_neg_next  = in_den[DW-1];
                    den_mag_next  = in_den[DW-1] ? -in_den : in_den;
                    m_neg_next    = in_num[DW-1];
                    m_mag_next    = in_num[DW-1] ? -in_num : in_num;
                    n_neg_next    = in_den[DW-1];
                    n_mag_next    = in_den[DW-1] ? -in_den : in_den;
                    zero_err_next = 1'b0;
                    ovf_next      = 1'b0;
                end
            end
            frgcd_pkg::OP_DIV_REM: begin
                div_req.start = 1'b1;
            end
            frgcd_pkg::OP_WB_REM: begin
                m_neg_next = n_neg_reg;
                m_mag_next = n_mag_reg;
                n_mag_next = div_rsp.remainder;
                n_neg_next = m_neg_reg & (div_rsp.remainder != '0);
            end
            frgcd_pkg::OP_DIV_NUM: begin
                div_req.start    = 1'b1;
                div_req.dividend = num_mag_reg;
                div_req.divisor  = m_mag_reg;
            end
            frgcd_pkg::OP_WB_QN: begin
                qn_next = q_neg_qn ? -q : q;
                if (!q_neg_qn && q[DW-1]) begin
                    ovf_next = 1'b1;
                end
            end
            frgcd_pkg::OP_DIV_DEN: begin
                div_req.start    = 1'b1;
                div_req.dividend = den_mag_reg;
                div_req.divisor  = m_mag_reg;
            end
            frgcd_pkg::OP_WB_QD: begin
                qd_next = q_neg_qd ? -q : q;
                if (!q_neg_qd && q[DW-1]) begin
                    ovf_next = 1'b1;
                end
            end
            frgcd_pkg::OP_ERR_ZERO: begin
                zero_err_next = 1'b1;
            end
            frgcd_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    m_tvalid_next = 1'b1;
                    if (zero_err_reg) begin
                        m_tdata_next = '0;
                        m_tuser_next = frgcd_pkg::ST_ZERO_DEN;
                    end else if (ovf_reg) begin
                        m_tdata_next = '0;
                        m_tuser_next = frgcd_pkg::ST_OVERFLOW;
                    end else begin
                        m_tdata_next = {qd_reg, qn_reg};
                        m_tuser_next = frgcd_pkg::ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= frgcd_pkg::PC_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_neg_reg  <= num_neg_next;
        num_mag_reg  <= num_mag_next;
        den_neg_reg  <= den_neg_next;
        den_mag_reg  <= den_mag_next;
        m_neg_reg    <= m_neg_next;
        m_mag_reg    <= m_mag_next;
        n_neg_reg    <= n_neg_next;
        n_mag_reg    <= n_mag_next;
        qn_reg       <= qn_next;
        qd_reg       <= qd_next;
        zero_err_reg <= zero_err_next;
        ovf_reg      <= ovf_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    frgcd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/frgcd_div.sv
// ----------------------------------------------------------------------------
// Fraction reduction divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frgcd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  frgcd_pkg::div_req_t req,
    output frgcd_pkg::div_rsp_t rsp
);

    logic                            busy_reg, busy_next;
    logic [frgcd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    frgcd_pkg::word_t                rem_reg, rem_next;
    frgcd_pkg::word_t                quo_reg, quo_next;
    frgcd_pkg::word_t                dvs_reg, dvs_next;
    logic [frgcd_pkg::DATA_WIDTH:0]  shifted;
    logic [frgcd_pkg::DATA_WIDTH:0]  diff;
    logic                            take;

    assign shifted = {rem_reg, quo_reg[frgcd_pkg::DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign take    = ~diff[frgcd_pkg::DATA_WIDTH];

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = frgcd_pkg::CNT_W'(frgcd_pkg::DATA_WIDTH - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = take ? diff[frgcd_pkg::DATA_WIDTH-1:0]
                            : shifted[frgcd_pkg::DATA_WIDTH-1:0];
            quo_next = {quo_reg[frgcd_pkg::DATA_WIDTH-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> rtl/fraction_reduce_gcd_checker.sv
// ----------------------------------------------------------------------------
// Fraction reduction port checker
// Watches the ports of the fraction reduction block over time.
// ----------------------------------------------------------------------------
`include "fraction_reduce_gcd_defines.svh"

module fraction_reduce_gcd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [frgcd_pkg::TDATA_W-1:0]  s_tdata,  // numerator, denominator
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [frgcd_pkg::TDATA_W-1:0]  m_tdata,  // reduced_numerator, reduced_denominator
    input logic [1:0]                     m_tuser   // status
);

    logic s_accept;
    logic in_stall;
    logic out_stall;
    logic status_legal;

    assign s_accept     = s_tvalid & s_tready;
    assign in_stall     = s_tvalid & ~s_tready;
    assign out_stall    = m_tvalid & ~m_tready;
    assign status_legal = (m_tuser == frgcd_pkg::ST_OK) ||
                          (m_tuser == frgcd_pkg::ST_ZERO_DEN) ||
                          (m_tuser == frgcd_pkg::ST_OVERFLOW);

    `FRGCD_ASSERT_NXT(a_out_word_holds, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `FRGCD_ASSERT_NXT(a_in_word_holds, in_stall, s_tvalid && $stable(s_tdata))
    `FRGCD_ASSERT_IMP(a_status_legal, m_tvalid, status_legal)
    `FRGCD_ASSERT_IMP(a_error_data_zero, m_tvalid && m_tuser != frgcd_pkg::ST_OK, m_tdata == '0)
    `FRGCD_ASSERT_NXT(a_busy_after_accept, s_accept, !s_tready)

endmodule

bind fraction_reduce_gcd fraction_reduce_gcd_checker u_checker (.*);
